>>> sv/low_shelf_biquad_filter_assert.svh
// Assertion helpers used by the filter RTL.
`ifndef LOW_SHELF_BIQUAD_FILTER_ASSERT_SVH
`define LOW_SHELF_BIQUAD_FILTER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define LSBQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lsbq assertion failed");

// Next-cycle implication, disabled while reset is held.
`define LSBQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lsbq assertion failed");

`endif

>>> sv/lsbq_pkg.sv
`default_nettype none
package lsbq_pkg;

    localparam int SMP_W   = 24;               // Q1.23 sample
    localparam int COEF_W  = 32;               // Q4.28 coefficient
    localparam int DLY_W   = 40;               // Q17.23 delay word
    localparam int FRAC    = 28;               // coefficient fraction bits
    localparam int DIG_W   = 4;                // coefficient digit per step
    localparam int NDIG    = COEF_W / DIG_W;
    localparam int NTERM   = 3;                // products per sum
    localparam int PROD_W  = DLY_W + DIG_W + 1;
    localparam int ACC_W   = 74;               // holds any sum of three products
    localparam int RND_W   = ACC_W - FRAC;     // rounded sum, Q.23
    localparam int DIFF_W  = RND_W + 1;        // x minus rounded feedback
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = COEF_W;
    localparam int SUB_W   = $clog2(NTERM);
    localparam int DCNT_W  = $clog2(NDIG);

    localparam logic [COEF_W-1:0] COEF_ONE = 32'h1000_0000;

    typedef logic signed [COEF_W-1:0] t_coef;
    typedef logic signed [DLY_W-1:0]  t_dly;
    typedef logic signed [SMP_W-1:0]  t_smp;
    typedef logic signed [RND_W-1:0]  t_rnd;

    typedef t_coef t_coef_set [NTERM];
    typedef t_dly  t_opd_set  [NTERM];

    typedef struct packed {
        logic busy;
        logic done;
    } t_mac_stat;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SHELF_ENABLE,
        REG_COEFF_B0,
        REG_COEFF_B1,
        REG_COEFF_B2,
        REG_COEFF_A1,
        REG_COEFF_A2
    } t_cfg_index;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FB,
        S_FF,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

>>> sv/lsbq_if.sv
`default_nettype none
interface lsbq_in_if import lsbq_pkg::*; ();
    logic valid;
    logic ready;
    logic channel;
    t_smp sample_in;

    modport source (output valid, output channel, output sample_in, input ready);
    modport sink   (input valid, input channel, input sample_in, output ready);
endinterface

interface lsbq_out_if import lsbq_pkg::*; ();
    logic valid;
    logic ready;
    logic out_channel;
    t_smp sample_out;
    logic clipped;

    modport source (output valid, output out_channel, output sample_out,
                    output clipped, input ready);
    modport sink   (input valid, input out_channel, input sample_out,
                    input clipped, output ready);
endinterface
`default_nettype wire

>>> sv/lsbq_mac.sv
`default_nettype none
// Digit-serial sum of three products, rounded to Q.23.
module lsbq_mac import lsbq_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_start,
    input  wire t_coef_set i_coef,
    input  wire t_opd_set  i_opd,
    output t_mac_stat      o_stat,
    output t_rnd           o_sum
);

    localparam logic [ACC_W-1:0] RND_HALF =
        {{(ACC_W-FRAC){1'b0}}, 1'b1, {(FRAC-1){1'b0}}};

    logic [COEF_W-1:0]       r_coef [NTERM];
    t_dly                    r_opd  [NTERM];
    logic signed [ACC_W-1:0] r_acc;
    t_rnd                    r_sum;
    logic                    r_busy, r_round, r_done;
    logic [SUB_W-1:0]        r_sub;
    logic [DCNT_W-1:0]       r_dig;

    logic [DIG_W-1:0]        w_digit;
    logic signed [DIG_W:0]   w_digit_ext;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [ACC_W-1:0] w_base;
    logic signed [ACC_W-1:0] n_acc;
    logic [ACC_W-1:0]        w_rnd;
    logic                    w_last_term;

    // Horner over coefficient digits, most significant first; the top digit is signed.
    always_comb begin
        w_digit     = r_coef[r_sub][COEF_W-1 -: DIG_W];
        w_digit_ext = (r_dig == '0) ? {w_digit[DIG_W-1], w_digit} : {1'b0, w_digit};
        w_prod      = PROD_W'(r_opd[r_sub]) * PROD_W'(w_digit_ext);
        w_base      = (r_sub == '0) ? (r_acc <<< DIG_W) : r_acc;
        n_acc       = w_base + ACC_W'(w_prod);
        w_rnd       = r_acc + RND_HALF;
        w_last_term = (r_sub == SUB_W'(NTERM - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_round <= 1'b0;
            r_done  <= 1'b0;
            r_sub   <= '0;
            r_dig   <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_round <= 1'b0;
                r_sub   <= '0;
                r_dig   <= '0;
            end else if (r_busy && !r_round) begin
                if (w_last_term) begin
                    r_sub <= '0;
                    if (r_dig == DCNT_W'(NDIG - 1)) begin
                        r_round <= 1'b1;
                    end else begin
                        r_dig <= r_dig + 1'b1;
                    end
                end else begin
                    r_sub <= r_sub + 1'b1;
                end
            end else if (r_round) begin
                r_round <= 1'b0;
                r_busy  <= 1'b0;
                r_done  <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            for (int k = 0; k < NTERM; k++) begin
                r_coef[k] <= i_coef[k];
                r_opd[k]  <= i_opd[k];
            end
            r_acc <= '0;
        end else if (r_busy && !r_round) begin
            r_acc         <= n_acc;
            r_coef[r_sub] <= r_coef[r_sub] << DIG_W;
        end else if (r_round) begin
            r_sum <= w_rnd[ACC_W-1:FRAC];
        end
    end

    assign o_stat = '{busy: r_busy, done: r_done};
    assign o_sum  = r_sum;

endmodule
`default_nettype wire

>>> sv/low_shelf_biquad_filter.sv
// Low-shelf biquad, direct form II, one pair of 40-bit delay words per channel.
// Input channel (i_in): valid/ready transaction of a channel number and a signed
// Q1.23 sample. Output channel (o_out): one transaction per input with the
// channel, the filtered sample saturated to 24 bits and a clip flag.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index
// (0 enable, 1..5 b0 b1 b2 a1 a2, Q4.28); other indexes are ignored. Write
// only while the block is idle.
// Timing: one item at a time. Each sum of products runs on a single
// digit-serial unit, one 4-bit coefficient digit times one delay word per
// cycle, then a rounding step per sum; two sums per sample. The filtered
// sample reaches the output register as the block returns to S_IDLE, where
// it takes the next input. A disabled or out-of-range sample passes through
// with no sum, straight to S_DONE; the block is ready again once S_DONE
// hands it over. The output register frees the input side: a new sample is
// taken while a result still waits; a finished result waits in S_DONE while
// the receiver stalls. Reset clears delays, loads reset coefficients and disables.
`default_nettype none
`include "low_shelf_biquad_filter_assert.svh"
module low_shelf_biquad_filter import lsbq_pkg::*; #(
    parameter int CHANNELS = 2
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    lsbq_in_if.sink                    i_in,
    lsbq_out_if.source                 o_out,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // configuration
    logic  r_shelf_enable;
    t_coef r_b0, r_b1, r_b2, r_a1, r_a2;

    // per-channel delay line
    t_dly r_delay_one [CHANNELS];
    t_dly r_delay_two [CHANNELS];

    // item in flight
    t_state r_state, n_state;
    logic   r_ch;
    t_smp   r_x;
    t_dly   r_w;
    t_smp   r_y;
    logic   r_clip;

    // output register
    logic r_out_valid, n_out_valid;
    logic r_out_ch;
    t_smp r_out_y;
    logic r_out_clip;

    logic [CH_W-1:0] w_in_idx, w_ch_idx;
    logic            w_in_active;
    logic            w_accept;
    logic            w_load_out;
    logic            w_mac_start;
    t_coef_set       w_coef;
    t_opd_set        w_opd;
    t_mac_stat       w_mac_stat;
    t_rnd            w_mac_sum;
    logic signed [DIFF_W-1:0] w_diff;
    t_dly            w_w_sat;
    t_smp            w_y_sat;
    logic            w_y_clip;

    assign w_in_idx    = CH_W'(i_in.channel);
    assign w_ch_idx    = CH_W'(r_ch);
    assign w_in_active = r_shelf_enable && (int'(i_in.channel) < CHANNELS);

    // Feedback result: w = x - round(a1*z1 + a2*z2), saturated to the delay range.
    always_comb begin
        w_diff = DIFF_W'(r_x) - DIFF_W'(w_mac_sum);
        if (!w_diff[DIFF_W-1] && (|w_diff[DIFF_W-2:DLY_W-1])) begin
            w_w_sat = {1'b0, {(DLY_W-1){1'b1}}};
        end else if (w_diff[DIFF_W-1] && !(&w_diff[DIFF_W-2:DLY_W-1])) begin
            w_w_sat = {1'b1, {(DLY_W-1){1'b0}}};
        end else begin
            w_w_sat = w_diff[DLY_W-1:0];
        end
    end

    // Feedforward result saturated to the sample range; flag the clip.
    always_comb begin
        w_y_clip = 1'b1;
        if (!w_mac_sum[RND_W-1] && (|w_mac_sum[RND_W-2:SMP_W-1])) begin
            w_y_sat = {1'b0, {(SMP_W-1){1'b1}}};
        end else if (w_mac_sum[RND_W-1] && !(&w_mac_sum[RND_W-2:SMP_W-1])) begin
            w_y_sat = {1'b1, {(SMP_W-1){1'b0}}};
        end else begin
            w_y_sat  = w_mac_sum[SMP_W-1:0];
            w_y_clip = 1'b0;
        end
    end

    // Sequencer: feedback sum, then feedforward sum, then hand over the result; a pass-through item skips both sums.
    always_comb begin
        n_state     = r_state;
        i_in.ready  = 1'b0;
        w_mac_start = 1'b0;
        w_load_out  = 1'b0;
        w_coef[0]   = r_a1;
        w_coef[1]   = r_a2;
        w_coef[2]   = '0;
        w_opd[0]    = r_delay_one[w_in_idx];
        w_opd[1]    = r_delay_two[w_in_idx];
        w_opd[2]    = '0;
        unique case (r_state)
            S_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    w_mac_start = w_in_active;
                    n_state     = w_in_active ? S_FB : S_DONE;
                end
            end
            S_FB: begin
                w_coef[0] = r_b0;
                w_coef[1] = r_b1;
                w_coef[2] = r_b2;
                w_opd[0]  = w_w_sat;
                w_opd[1]  = r_delay_one[w_ch_idx];
                w_opd[2]  = r_delay_two[w_ch_idx];
                if (w_mac_stat.done) begin
                    w_mac_start = 1'b1;
                    n_state     = S_FF;
                end
            end
            S_FF: begin
                if (w_mac_stat.done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    w_load_out = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_out_valid = w_load_out || (r_out_valid && !o_out.ready);
    end

    assign w_accept = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Configuration registers; ignore unknown indexes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shelf_enable <= 1'b0;
            r_b0 <= COEF_ONE;
            r_b1 <= '0;
            r_b2 <= '0;
            r_a1 <= '0;
            r_a2 <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                REG_SHELF_ENABLE: r_shelf_enable <= i_cfg_data[0];
                REG_COEFF_B0:     r_b0 <= i_cfg_data;
                REG_COEFF_B1:     r_b1 <= i_cfg_data;
                REG_COEFF_B2:     r_b2 <= i_cfg_data;
                REG_COEFF_A1:     r_a1 <= i_cfg_data;
                REG_COEFF_A2:     r_a2 <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Advance the delay pair once the feedforward sum is done.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_delay_one[c] <= '0;
                r_delay_two[c] <= '0;
            end
        end else if (r_state == S_FF && w_mac_stat.done) begin
            r_delay_two[w_ch_idx] <= r_delay_one[w_ch_idx];
            r_delay_one[w_ch_idx] <= r_w;
        end
    end

    // Item payload; a pass-through item takes its sample as the result.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ch   <= i_in.channel;
            r_x    <= i_in.sample_in;
            r_y    <= i_in.sample_in;
            r_clip <= 1'b0;
        end
        if (r_state == S_FB && w_mac_stat.done) begin
            r_w <= w_w_sat;
        end
        if (r_state == S_FF && w_mac_stat.done) begin
            r_y    <= w_y_sat;
            r_clip <= w_y_clip;
        end
        if (w_load_out) begin
            r_out_ch   <= r_ch;
            r_out_y    <= r_y;
            r_out_clip <= r_clip;
        end
    end

    lsbq_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mac_start),
        .i_coef  (w_coef),
        .i_opd   (w_opd),
        .o_stat  (w_mac_stat),
        .o_sum   (w_mac_sum)
    );

    assign o_out.valid       = r_out_valid;
    assign o_out.out_channel = r_out_ch;
    assign o_out.sample_out  = r_out_y;
    assign o_out.clipped     = r_out_clip;

    `LSBQ_ASSERT_NOW(a_start_when_free, i_clk, i_rst_n, w_mac_start, !w_mac_stat.busy)
    `LSBQ_ASSERT_NOW(a_done_in_sum, i_clk, i_rst_n, w_mac_stat.done, (r_state == S_FB || r_state == S_FF))
    `LSBQ_ASSERT_NEXT(a_delay_hold, i_clk, i_rst_n, (r_state != S_FF), $stable(r_delay_one[0]))
    `LSBQ_ASSERT_NOW(a_out_from_done, i_clk, i_rst_n, $rose(r_out_valid), ($past(r_state) == S_DONE))

endmodule
`default_nettype wire
